// File: hw/rtl/cnt_pkg.sv
package cnt_pkg;

  localparam int NEST_LEVEL_W = 6;

  typedef enum logic [1:0] {
    OP_IF    = 2'd0,
    OP_ELIF  = 2'd1,
    OP_ELSE  = 2'd2,
    OP_ENDIF = 2'd3
  } dir_op_t;

  typedef struct packed {
    dir_op_t op;
    logic    cond_value;
    logic    cond_failed;
  } in_item_t;

  typedef struct packed {
    logic                    active;
    logic                    considered;
    logic                    malformed;
    logic [NEST_LEVEL_W-1:0] nest_level;
  } out_item_t;

  // bits kept for one open conditional level
  typedef struct packed {
    logic active;
    logic taken;
    logic else_seen;
  } level_t;

  typedef enum logic [1:0] {
    STK_HOLD  = 2'd0,
    STK_PUSH  = 2'd1,
    STK_POP   = 2'd2,
    STK_WRITE = 2'd3
  } stk_op_t;

  typedef struct packed {
    stk_op_t op;
    level_t  lvl;
  } stk_cmd_t;

endpackage

// File: hw/rtl/cnt_stream_if.sv
interface cnt_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/conditional_nesting_tracker.sv
// a registered result appears in the cycle after its directive transaction is accepted
// throughput: one directive per cycle unless out_if stalls; stack updated in the accept cycle
// and the level below the parent is prefetched from the stack memory each cycle
// reset (rst_n low, synchronous): depth 0, no result pending, active_on_error 0
// level storage is not cleared; every level is written when it is opened
module conditional_nesting_tracker
  import cnt_pkg::*;
#(
  parameter int MAX_NEST = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  cnt_stream_if.sink   in_if,
  cnt_stream_if.source out_if,
  cnt_stream_if.sink   cfg_if
);

  localparam int DW = $clog2(MAX_NEST + 1);

  logic          aoe_r;
  logic          out_valid_r;
  out_item_t     out_r, out_nxt;
  in_item_t      item;
  logic          in_acc;
  logic [DW-1:0] depth, depth_after;
  level_t        top, lvl;
  logic          parent_active, po;
  logic          bad, consd;
  stk_cmd_t      cmd;

  assign item         = in_if.data;
  assign in_if.ready  = !out_valid_r || out_if.ready;
  assign in_acc       = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;

  always_comb begin
    lvl    = top;
    bad    = 1'b0;
    consd  = 1'b0;
    cmd.op = STK_HOLD;
    po     = (depth <= DW'(1)) || parent_active;
    unique case (item.op)
      OP_IF: begin
        if (depth == DW'(MAX_NEST)) begin
          bad = 1'b1;
        end else begin
          cmd.op = STK_PUSH;
          lvl    = '0;
          // the parent of the new level is the current top
          if (depth == '0 || top.active) begin
            if (item.cond_failed) begin
              bad = 1'b1;
            end else begin
              lvl.active = item.cond_value;
              lvl.taken  = item.cond_value;
              consd      = 1'b1;
            end
          end
        end
      end
      OP_ELIF: begin
        if (depth == '0 || top.else_seen) begin
          bad = 1'b1;
        end else begin
          cmd.op = STK_WRITE;
          if (top.taken) begin
            lvl.active = 1'b0;
          end else if (po) begin
            if (item.cond_failed) begin
              bad = 1'b1;
            end else begin
              if (item.cond_value) begin
                lvl.active = 1'b1;
                lvl.taken  = 1'b1;
              end
              consd = 1'b1;
            end
          end
        end
      end
      OP_ELSE: begin
        if (depth == '0 || top.else_seen) begin
          bad = 1'b1;
        end else begin
          cmd.op        = STK_WRITE;
          lvl.else_seen = 1'b1;
          if (top.taken) begin
            lvl.active = 1'b0;
          end else if (po) begin
            lvl.active = 1'b1;
            lvl.taken  = 1'b1;
            consd      = 1'b1;
          end
        end
      end
      OP_ENDIF: begin
        if (depth == '0) begin
          bad = 1'b1;
        end else begin
          cmd.op = STK_POP;
          consd  = 1'b1;
        end
      end
      default: ;
    endcase
    if (bad) begin
      consd = 1'b0;
      if (aoe_r) begin
        lvl.active = 1'b1;
        if (cmd.op == STK_HOLD) begin
          cmd.op = STK_WRITE;
        end
      end
    end
    if (!in_acc) begin
      cmd.op = STK_HOLD;
    end
    cmd.lvl = lvl;
  end

  always_comb begin
    if (item.op == OP_IF && cmd.op == STK_PUSH) begin
      depth_after = depth + DW'(1);
    end else if (item.op == OP_ENDIF && cmd.op == STK_POP) begin
      depth_after = depth - DW'(1);
    end else begin
      depth_after = depth;
    end
    out_nxt.considered = consd;
    out_nxt.malformed  = bad;
    out_nxt.nest_level = NEST_LEVEL_W'(depth_after);
    if (depth_after == '0) begin
      out_nxt.active = 1'b1;
    end else if (cmd.op == STK_POP) begin
      out_nxt.active = parent_active;
    end else begin
      out_nxt.active = lvl.active;
    end
  end

  cnt_level_stack #(
    .MAX_NEST(MAX_NEST)
  ) u_stack (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .depth        (depth),
    .top          (top),
    .parent_active(parent_active)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      aoe_r       <= 1'b0;
    end else begin
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_if.valid && cfg_if.ready) begin
        aoe_r <= cfg_if.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_r <= out_nxt;
    end
  end

  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_r;

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth <= DW'(MAX_NEST))
    else $error("nesting depth beyond limit");

  a_result_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r ##1 out_valid_r) |-> $past(in_acc))
    else $error("result without accepted directive");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.malformed && out_r.considered))
    else $error("malformed directive marked considered");

  a_if_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && item.op == OP_IF && depth == DW'(MAX_NEST))
      |=> (out_r.malformed && depth == $past(depth)))
    else $error("if beyond limit not flagged or depth moved");

endmodule

// File: hw/rtl/cnt_level_stack.sv
module cnt_level_stack
  import cnt_pkg::*;
#(
  parameter int MAX_NEST = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  stk_cmd_t                         cmd,
  output logic [$clog2(MAX_NEST+1)-1:0]    depth,
  output level_t                           top,
  output logic                             parent_active
);

  localparam int DW = $clog2(MAX_NEST + 1);
  localparam int IW = $clog2(MAX_NEST);

  // top holds level depth, second holds level depth-1, the memory the rest
  level_t          mem [MAX_NEST];
  logic [DW-1:0]   depth_r, depth_nxt;
  level_t          top_r, top_nxt;
  level_t          second_r, second_nxt;
  level_t          below_r;
  logic [IW-1:0]   waddr, raddr;
  logic            mem_we;

  always_comb begin
    depth_nxt  = depth_r;
    top_nxt    = top_r;
    second_nxt = second_r;
    unique case (cmd.op)
      STK_PUSH: begin
        depth_nxt  = depth_r + DW'(1);
        top_nxt    = cmd.lvl;
        second_nxt = top_r;
      end
      STK_POP: begin
        depth_nxt  = depth_r - DW'(1);
        top_nxt    = second_r;
        second_nxt = below_r;
      end
      STK_WRITE: top_nxt = cmd.lvl;
      default: ;
    endcase
  end

  assign mem_we = (cmd.op == STK_PUSH) && (depth_r >= DW'(2));
  assign waddr  = IW'(depth_r - DW'(1));
  // prefetch the level two below the next top, for the next pop
  assign raddr  = (depth_nxt >= DW'(2)) ? IW'(depth_nxt - DW'(2)) : '0;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= second_r;
    end
    if (cmd.op == STK_PUSH) begin
      below_r <= second_r;
    end else begin
      below_r <= mem[raddr];
    end
    top_r    <= top_nxt;
    second_r <= second_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else begin
      depth_r <= depth_nxt;
    end
  end

  assign depth         = depth_r;
  assign top           = top_r;
  assign parent_active = second_r.active;

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == STK_POP) |-> (depth_r != '0))
    else $error("pop with no open level");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == STK_PUSH) |=> (depth_r == $past(depth_r) + DW'(1)))
    else $error("push did not raise depth");

endmodule
